// File: design/rrt_pkg.sv
// ----------------------------------------------------------------------------
// rrt_pkg
// shared constants, codes and types of the request router with timeout
// ----------------------------------------------------------------------------
package rrt_pkg;

    localparam int NUM_CLIENTS = 2;
    localparam int NUM_SERVERS = 2;
    localparam int TIMER_WIDTH = 16;

    localparam int ID_W       = 8;
    localparam int SIZE_W     = 9;
    localparam int TIMEOUT_W  = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    localparam logic [SIZE_W-1:0] REQ_MIN_LEN = SIZE_W'(5);
    localparam logic [SIZE_W-1:0] RSP_MIN_LEN = SIZE_W'(5);

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int CNT_W      = 3;

    typedef enum logic [1:0] {
        CMD_REQUEST  = 2'd0,
        CMD_RESPONSE = 2'd1,
        CMD_TICK     = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        K_TO_SERVER = 3'd0,
        K_TO_CLIENT = 3'd1,
        K_NO_ROUTE  = 3'd2,
        K_TIMEOUT   = 3'd3,
        K_IGNORED   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_PENDING = 3'b010,
        PH_WAIT    = 3'b100
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SERVER_ID_0      = 3'd0,
        REG_SERVER_ID_1      = 3'd1,
        REG_SERVER_ENABLE    = 3'd2,
        REG_CLIENT_ENABLE    = 3'd3,
        REG_CLIENT_TIMEOUT_0 = 3'd4,
        REG_CLIENT_TIMEOUT_1 = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]        command;
        logic              port;
        logic [ID_W-1:0]   msg_id;
        logic [SIZE_W-1:0] msg_size;
    } event_t;

    typedef struct packed {
        kind_t             kind;
        logic              client_index;
        logic              server_index;
        logic [ID_W-1:0]   out_id;
        logic [SIZE_W-1:0] out_size;
        logic              last;
    } result_t;

    // up to two results written to the queue together
    typedef struct packed {
        logic [1:0]    count;
        result_t [1:0] res;
    } push_t;

    typedef struct packed {
        logic [NUM_SERVERS-1:0][ID_W-1:0]      server_id;
        logic [NUM_SERVERS-1:0]                server_enable;
        logic [NUM_CLIENTS-1:0]                client_enable;
        logic [NUM_CLIENTS-1:0][TIMEOUT_W-1:0] client_timeout;
    } cfg_t;

    function automatic result_t mk_result(kind_t k, logic c, logic s,
                                          logic [ID_W-1:0] id, logic [SIZE_W-1:0] size);
        result_t r;
        r.kind         = k;
        r.client_index = c;
        r.server_index = s;
        r.out_id       = id;
        r.out_size     = size;
        r.last         = 1'b0;
        return r;
    endfunction

endpackage

// File: design/rrt_channels.sv
// ----------------------------------------------------------------------------
// rrt channels
// valid/ready channels for incoming events and outgoing results
// ----------------------------------------------------------------------------
interface rrt_event_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic       port;
    logic [7:0] msg_id;
    logic [8:0] msg_size;

    modport source (output valid, command, port, msg_id, msg_size, input ready);
    modport sink   (input valid, command, port, msg_id, msg_size, output ready);
endinterface

interface rrt_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic       client_index;
    logic       server_index;
    logic [7:0] out_id;
    logic [8:0] out_size;
    logic       last;

    modport source (output valid, kind, client_index, server_index, out_id, out_size, last,
                    input ready);
    modport sink   (input valid, kind, client_index, server_index, out_id, out_size, last,
                    output ready);
endinterface

// File: design/rrt_cfg_regs.sv
// ----------------------------------------------------------------------------
// rrt_cfg_regs
// configuration register bank written through a plain write port
// ----------------------------------------------------------------------------
module rrt_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [rrt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rrt_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output rrt_pkg::cfg_t                  cfg
);
    import rrt_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_SERVER_ID_0:      cfg_next.server_id[0]      = cfg_wdata[ID_W-1:0];
                REG_SERVER_ID_1:      cfg_next.server_id[1]      = cfg_wdata[ID_W-1:0];
                REG_SERVER_ENABLE:    cfg_next.server_enable     = cfg_wdata[NUM_SERVERS-1:0];
                REG_CLIENT_ENABLE:    cfg_next.client_enable     = cfg_wdata[NUM_CLIENTS-1:0];
                REG_CLIENT_TIMEOUT_0: cfg_next.client_timeout[0] = cfg_wdata[TIMEOUT_W-1:0];
                REG_CLIENT_TIMEOUT_1: cfg_next.client_timeout[1] = cfg_wdata[TIMEOUT_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: design/rrt_engine.sv
// ----------------------------------------------------------------------------
// rrt_engine
// event input register, client and server state, and the routing step
// ----------------------------------------------------------------------------
module rrt_engine (
    input  logic            clk,
    input  logic            rst_n,
    input  rrt_pkg::cfg_t   cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  rrt_pkg::event_t in_item,
    input  logic            room,
    output rrt_pkg::push_t  push
);
    import rrt_pkg::*;

    logic   ev_valid_reg;
    logic   ev_valid_next;
    event_t ev_reg;

    phase_t                 phase_reg    [NUM_CLIENTS];
    phase_t                 phase_next   [NUM_CLIENTS];
    logic                   target_reg   [NUM_CLIENTS];
    logic                   target_next  [NUM_CLIENTS];
    logic [TIMER_WIDTH-1:0] timer_reg    [NUM_CLIENTS];
    logic [TIMER_WIDTH-1:0] timer_next   [NUM_CLIENTS];
    logic [ID_W-1:0]        req_id_reg   [NUM_CLIENTS];
    logic [ID_W-1:0]        req_id_next  [NUM_CLIENTS];
    logic [SIZE_W-1:0]      req_size_reg [NUM_CLIENTS];
    logic [SIZE_W-1:0]      req_size_next[NUM_CLIENTS];
    logic [NUM_SERVERS-1:0] busy_reg;
    logic [NUM_SERVERS-1:0] busy_next;

    logic    process;
    logic    in_accept;
    result_t res [2];
    logic [1:0] n;

    assign process   = ev_valid_reg && room;
    assign in_ready  = !ev_valid_reg || process;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        if (in_accept)
            ev_valid_next = 1'b1;
        else if (process)
            ev_valid_next = 1'b0;
        else
            ev_valid_next = ev_valid_reg;
    end

    // one event: state update and up to two results
    always_comb
    begin
        logic found_match;
        logic found_zero;
        logic pick_match;
        logic pick_zero;
        logic pick;
        logic done;
        logic c;
        logic s;
        logic t;

        found_match = 1'b0;
        found_zero  = 1'b0;
        pick_match  = 1'b0;
        pick_zero   = 1'b0;
        pick        = 1'b0;
        done        = 1'b0;
        c           = ev_reg.port;
        s           = ev_reg.port;
        t           = 1'b0;
        n           = 2'd0;
        res[0]      = '0;
        res[1]      = '0;
        busy_next   = busy_reg;
        for (int i = 0; i < NUM_CLIENTS; i++)
        begin
            phase_next[i]    = phase_reg[i];
            target_next[i]   = target_reg[i];
            timer_next[i]    = timer_reg[i];
            req_id_next[i]   = req_id_reg[i];
            req_size_next[i] = req_size_reg[i];
        end

        if (process)
        begin
            case (ev_reg.command)
                CMD_REQUEST:
                begin
                    // lowest server wins: scan downward so the last hit is kept
                    for (int j = NUM_SERVERS - 1; j >= 0; j--)
                    begin
                        if (cfg.server_enable[j] && cfg.server_id[j] == ev_reg.msg_id)
                        begin
                            found_match = 1'b1;
                            pick_match  = 1'(j);
                        end
                        if (cfg.server_enable[j] && cfg.server_id[j] == '0)
                        begin
                            found_zero = 1'b1;
                            pick_zero  = 1'(j);
                        end
                    end
                    pick = found_match ? pick_match : pick_zero;

                    if (!cfg.client_enable[c] || phase_reg[c] != PH_IDLE ||
                        ev_reg.msg_size < REQ_MIN_LEN)
                    begin
                        res[0] = mk_result(K_IGNORED, c, 1'b0, '0, '0);
                        n      = 2'd1;
                    end
                    else if (!found_match && !found_zero)
                    begin
                        res[0] = mk_result(K_NO_ROUTE, c, 1'b0, ev_reg.msg_id, ev_reg.msg_size);
                        n      = 2'd1;
                    end
                    else
                    begin
                        target_next[c]   = pick;
                        req_id_next[c]   = ev_reg.msg_id;
                        req_size_next[c] = ev_reg.msg_size;
                        if (busy_reg[pick])
                        begin
                            phase_next[c] = PH_PENDING;
                        end
                        else
                        begin
                            busy_next[pick] = 1'b1;
                            timer_next[c]   = TIMER_WIDTH'(cfg.client_timeout[c]);
                            phase_next[c]   = PH_WAIT;
                            res[0] = mk_result(K_TO_SERVER, c, pick, ev_reg.msg_id,
                                               ev_reg.msg_size);
                            n      = 2'd1;
                        end
                    end
                end

                CMD_RESPONSE:
                begin
                    if (ev_reg.msg_size >= RSP_MIN_LEN)
                    begin
                        for (int i = 0; i < NUM_CLIENTS; i++)
                        begin
                            if (!done && cfg.client_enable[i] && phase_reg[i] == PH_WAIT &&
                                target_reg[i] == s)
                            begin
                                busy_next[s]  = 1'b0;
                                phase_next[i] = PH_IDLE;
                                res[0] = mk_result(K_TO_CLIENT, 1'(i), s, ev_reg.msg_id,
                                                   ev_reg.msg_size);
                                done   = 1'b1;
                            end
                        end
                    end
                    if (!done)
                        res[0] = mk_result(K_IGNORED, 1'b0, s, '0, '0);
                    n = 2'd1;
                end

                CMD_TICK:
                begin
                    // client 0 first; its busy update is seen by client 1
                    for (int i = 0; i < NUM_CLIENTS; i++)
                    begin
                        t = target_reg[i];
                        if (cfg.client_enable[i])
                        begin
                            if (phase_reg[i] == PH_PENDING)
                            begin
                                if (!busy_next[t])
                                begin
                                    busy_next[t]  = 1'b1;
                                    timer_next[i] = TIMER_WIDTH'(cfg.client_timeout[i]);
                                    phase_next[i] = PH_WAIT;
                                    res[n[0]] = mk_result(K_TO_SERVER, 1'(i), t,
                                                          req_id_reg[i], req_size_reg[i]);
                                    n = n + 2'd1;
                                end
                            end
                            else if (phase_reg[i] == PH_WAIT)
                            begin
                                if (timer_reg[i] != '0)
                                begin
                                    timer_next[i] = timer_reg[i] - TIMER_WIDTH'(1);
                                end
                                else
                                begin
                                    busy_next[t]  = 1'b0;
                                    phase_next[i] = PH_IDLE;
                                    res[n[0]] = mk_result(K_TIMEOUT, 1'(i), t, '0, '0);
                                    n = n + 2'd1;
                                end
                            end
                        end
                    end
                end

                default:
                begin
                    res[0] = mk_result(K_IGNORED, 1'b0, 1'b0, '0, '0);
                    n      = 2'd1;
                end
            endcase

            if (n == 2'd1)
                res[0].last = 1'b1;
            else if (n == 2'd2)
                res[1].last = 1'b1;
        end
    end

    assign push.count  = n;
    assign push.res[0] = res[0];
    assign push.res[1] = res[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg <= 1'b0;
            busy_reg     <= '0;
            for (int i = 0; i < NUM_CLIENTS; i++)
            begin
                phase_reg[i]    <= PH_IDLE;
                target_reg[i]   <= 1'b0;
                timer_reg[i]    <= '0;
                req_id_reg[i]   <= '0;
                req_size_reg[i] <= '0;
            end
        end
        else
        begin
            ev_valid_reg <= ev_valid_next;
            busy_reg     <= busy_next;
            for (int i = 0; i < NUM_CLIENTS; i++)
            begin
                phase_reg[i]    <= phase_next[i];
                target_reg[i]   <= target_next[i];
                timer_reg[i]    <= timer_next[i];
                req_id_reg[i]   <= req_id_next[i];
                req_size_reg[i] <= req_size_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            ev_reg <= in_item;
    end

endmodule

// File: design/rrt_result_fifo.sv
// ----------------------------------------------------------------------------
// rrt_result_fifo
// small result queue taking up to two results a cycle, giving one
// ----------------------------------------------------------------------------
module rrt_result_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  rrt_pkg::push_t   push,
    input  logic             pop,
    output logic             out_valid,
    output rrt_pkg::result_t out_item,
    output logic             room
);
    import rrt_pkg::*;

    result_t          mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_pop;

    assign out_valid = count_reg != '0;
    assign out_item  = mem[rd_ptr_reg];
    assign room      = count_reg <= CNT_W'(FIFO_DEPTH - 2);
    assign do_pop    = pop && out_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(do_pop);
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_ptr_reg] <= push.res[0];
        if (push.count == 2'd2)
            mem[wr_ptr_reg + PTR_W'(1)] <= push.res[1];
    end

endmodule

// File: design/request_router_with_timeout_unit.sv
// ----------------------------------------------------------------------------
// request_router_with_timeout_unit
// routes client requests to servers, forwards responses, times out clients
// ----------------------------------------------------------------------------
// An event (request, response or tick) is taken into an input register and
// handled in one pass of short logic that updates the client and server
// state and writes its one or two results into a four-entry result queue;
// the first result passes the input register and the queue before it reaches
// the result port. A new event is taken every cycle while the queue has two
// free entries. The result port gives one transaction per cycle while it is
// not stalled, so events with one result run at one per cycle and ticks that
// give two results more slowly. A request whose server is busy gives no result
// and only updates state. Configuration writes take effect at the next clock
// edge and are meant for idle periods only.
// ----------------------------------------------------------------------------
module request_router_with_timeout_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    rrt_event_if.sink                      events,
    rrt_result_if.source                   results,
    input  logic                           cfg_wr_en,
    input  logic [rrt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rrt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import rrt_pkg::*;

    cfg_t    cfg;
    event_t  in_item;
    push_t   push;
    result_t out_item;
    logic    room;
    logic    out_valid;

    // register bank
    rrt_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // incoming event transaction payload
    assign in_item.command  = events.command;
    assign in_item.port     = events.port;
    assign in_item.msg_id   = events.msg_id;
    assign in_item.msg_size = events.msg_size;

    // routing and timeout state
    rrt_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (events.valid),
        .in_ready (events.ready),
        .in_item  (in_item),
        .room     (room),
        .push     (push)
    );

    // result queue decouples the engine from a stalled result port
    rrt_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (results.ready),
        .out_valid (out_valid),
        .out_item  (out_item),
        .room      (room)
    );

    // outgoing result transaction
    assign results.valid        = out_valid;
    assign results.kind         = out_item.kind;
    assign results.client_index = out_item.client_index;
    assign results.server_index = out_item.server_index;
    assign results.out_id       = out_item.out_id;
    assign results.out_size     = out_item.out_size;
    assign results.last         = out_item.last;

endmodule

// File: design/rrt_checker.sv
// ----------------------------------------------------------------------------
// rrt_checker
// port-level checks of the request router, bound to the top level
// ----------------------------------------------------------------------------
module rrt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] kind,
    input logic [7:0] out_id,
    input logic [8:0] out_size,
    input logic       last
);
    import rrt_pkg::*;

    // a stalled result transaction holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_id) &&
        $stable(out_size) && $stable(last))
        else $error("result changed while stalled");

    // the second result of an event follows without a gap
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid)
        else $error("second result of an event missing");

    // only ticks give two results: sends and timeouts
    a_first_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> kind == K_TO_SERVER || kind == K_TIMEOUT)
        else $error("unexpected kind on a non-final result");

    // timeouts and ignored events carry no message
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == K_TIMEOUT || kind == K_IGNORED) |->
        out_id == '0 && out_size == '0)
        else $error("message fields set on an empty result");

endmodule

bind request_router_with_timeout_unit rrt_checker u_rrt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .kind      (results.kind),
    .out_id    (results.out_id),
    .out_size  (results.out_size),
    .last      (results.last)
);

// File: sim/request_router_with_timeout_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// request_router_with_timeout_unit_tb
// self-checking bench: a predictor of the routing, busy and timeout state
// works out the results of every accepted event, and a monitor compares each
// result transaction field by field; directed events first, then random
// phases under different register settings and idle/stall patterns
// ----------------------------------------------------------------------------
module request_router_with_timeout_unit_tb;
    import rrt_pkg::*;

    // command code with no meaning for the block
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEMS_PER_PHASE = 54;
    localparam int RANDOM_PHASES = 8;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    rrt_event_if ev_if ();
    rrt_result_if res_if ();

    request_router_with_timeout_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .events    (ev_if.sink),
        .results   (res_if.source),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor state: register copies and per-client / per-server state
    // ------------------------------------------------------------------
    logic [ID_W-1:0]        cfg_server_id [NUM_SERVERS];
    logic [NUM_SERVERS-1:0] cfg_server_en;
    logic [NUM_CLIENTS-1:0] cfg_client_en;
    logic [TIMEOUT_W-1:0]   cfg_timeout [NUM_CLIENTS];

    phase_t                 cl_phase [NUM_CLIENTS];
    logic                   cl_target [NUM_CLIENTS];
    logic [TIMER_WIDTH-1:0] cl_timer [NUM_CLIENTS];
    logic [ID_W-1:0]        cl_req_id [NUM_CLIENTS];
    logic [SIZE_W-1:0]      cl_req_size [NUM_CLIENTS];
    logic                   srv_busy [NUM_SERVERS];

    event_t  event_queue [$];        // events waiting to be driven
    result_t expected_results [$];   // results the block still owes

    int send_idle_pct;
    int recv_stall_pct;
    int error_count;
    int cycle_count;

    function automatic result_t make_result(kind_t k, logic c, logic s,
                                            logic [ID_W-1:0] id, logic [SIZE_W-1:0] size);
        result_t r;
        r.kind         = k;
        r.client_index = c;
        r.server_index = s;
        r.out_id       = id;
        r.out_size     = size;
        r.last         = 1'b0;
        return r;
    endfunction

    // client c hands its stored request to its server: server goes busy,
    // timer reloads and the client waits for the response
    function automatic result_t launch_request(logic c);
        logic s;
        s = cl_target[c];
        srv_busy[s] = 1'b1;
        cl_timer[c] = cfg_timeout[c][TIMER_WIDTH-1:0];
        cl_phase[c] = PH_WAIT;
        return make_result(K_TO_SERVER, c, s, cl_req_id[c], cl_req_size[c]);
    endfunction

    // advance the predicted state by one accepted event and queue its results
    task automatic route_event(input event_t e);
        result_t batch [$];
        logic c;
        logic s;
        bit found;
        bit done;
        logic pick;
        found = 0;
        done  = 0;
        pick  = 1'b0;
        c     = e.port;
        s     = e.port;
        case (e.command)
            CMD_REQUEST:
            begin
                if (!cfg_client_en[c] || cl_phase[c] != PH_IDLE || e.msg_size < REQ_MIN_LEN)
                    batch.push_back(make_result(K_IGNORED, c, 1'b0, '0, '0));
                else
                begin
                    // exact id match first, catch-all server second
                    for (int i = 0; i < NUM_SERVERS; i++)
                        if (!found && cfg_server_en[i] && cfg_server_id[i] == e.msg_id)
                        begin
                            found = 1;
                            pick  = 1'(i);
                        end
                    for (int i = 0; i < NUM_SERVERS; i++)
                        if (!found && cfg_server_en[i] && cfg_server_id[i] == '0)
                        begin
                            found = 1;
                            pick  = 1'(i);
                        end
                    if (!found)
                        batch.push_back(make_result(K_NO_ROUTE, c, 1'b0, e.msg_id, e.msg_size));
                    else
                    begin
                        cl_target[c]   = pick;
                        cl_req_id[c]   = e.msg_id;
                        cl_req_size[c] = e.msg_size;
                        // busy server: client parks until a tick finds it free
                        if (srv_busy[pick])
                            cl_phase[c] = PH_PENDING;
                        else
                            batch.push_back(launch_request(c));
                    end
                end
            end
            CMD_RESPONSE:
            begin
                if (e.msg_size >= RSP_MIN_LEN)
                    for (int i = 0; i < NUM_CLIENTS; i++)
                        if (!done && cfg_client_en[i] && cl_phase[i] == PH_WAIT &&
                            cl_target[i] == s)
                        begin
                            srv_busy[s] = 1'b0;
                            cl_phase[i] = PH_IDLE;
                            batch.push_back(make_result(K_TO_CLIENT, 1'(i), s,
                                                        e.msg_id, e.msg_size));
                            done = 1;
                        end
                if (!done)
                    batch.push_back(make_result(K_IGNORED, 1'b0, s, '0, '0));
            end
            CMD_TICK:
            begin
                // client 0 first, so a timeout of client 0 can free the
                // server that client 1 is waiting for in the same tick
                for (int i = 0; i < NUM_CLIENTS; i++)
                begin
                    if (cfg_client_en[i])
                    begin
                        if (cl_phase[i] == PH_PENDING)
                        begin
                            if (!srv_busy[cl_target[i]])
                                batch.push_back(launch_request(1'(i)));
                        end
                        else if (cl_phase[i] == PH_WAIT)
                        begin
                            if (cl_timer[i] != '0)
                                cl_timer[i] = cl_timer[i] - TIMER_WIDTH'(1);
                            else
                            begin
                                srv_busy[cl_target[i]] = 1'b0;
                                cl_phase[i] = PH_IDLE;
                                batch.push_back(make_result(K_TIMEOUT, 1'(i), cl_target[i],
                                                            '0, '0));
                            end
                        end
                    end
                end
            end
            default: batch.push_back(make_result(K_IGNORED, 1'b0, 1'b0, '0, '0));
        endcase
        if (batch.size() > 0)
            batch[batch.size()-1].last = 1'b1;
        foreach (batch[i])
            expected_results.push_back(batch[i]);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d, expected %0d", cycle_count, what, got, want);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // event driver: presents the head of event_queue, holds it until the
    // transaction completes, idles at random
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_if.valid    <= 1'b0;
            ev_if.command  <= '0;
            ev_if.port     <= 1'b0;
            ev_if.msg_id   <= '0;
            ev_if.msg_size <= '0;
        end
        else
        begin
            if (ev_if.valid && ev_if.ready)
                route_event(event_queue.pop_front());
            // free to present the next event unless one is still on offer
            if (!ev_if.valid || ev_if.ready)
            begin
                if (event_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    ev_if.valid    <= 1'b1;
                    ev_if.command  <= event_queue[0].command;
                    ev_if.port     <= event_queue[0].port;
                    ev_if.msg_id   <= event_queue[0].msg_id;
                    ev_if.msg_size <= event_queue[0].msg_size;
                end
                else
                    ev_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor: random back-pressure, compares each transaction with
    // the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        result_t want;
        if (!rst_n)
            res_if.ready <= 1'b0;
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result, kind", int'(res_if.kind), -1);
                else
                begin
                    want = expected_results.pop_front();
                    if (res_if.kind !== want.kind)
                        report_mismatch("kind", int'(res_if.kind), int'(want.kind));
                    if (res_if.client_index !== want.client_index)
                        report_mismatch("client_index", int'(res_if.client_index),
                                        int'(want.client_index));
                    if (res_if.server_index !== want.server_index)
                        report_mismatch("server_index", int'(res_if.server_index),
                                        int'(want.server_index));
                    if (res_if.out_id !== want.out_id)
                        report_mismatch("out_id", int'(res_if.out_id), int'(want.out_id));
                    if (res_if.out_size !== want.out_size)
                        report_mismatch("out_size", int'(res_if.out_size), int'(want.out_size));
                    if (res_if.last !== want.last)
                        report_mismatch("last", int'(res_if.last), int'(want.last));
                end
            end
            res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // register write, mirrored into the predictor; only used while idle
    task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_SERVER_ID_0:      cfg_server_id[0] = value[ID_W-1:0];
            REG_SERVER_ID_1:      cfg_server_id[1] = value[ID_W-1:0];
            REG_SERVER_ENABLE:    cfg_server_en    = value[NUM_SERVERS-1:0];
            REG_CLIENT_ENABLE:    cfg_client_en    = value[NUM_CLIENTS-1:0];
            REG_CLIENT_TIMEOUT_0: cfg_timeout[0]   = value[TIMEOUT_W-1:0];
            REG_CLIENT_TIMEOUT_1: cfg_timeout[1]   = value[TIMEOUT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] id0, input logic [7:0] id1,
                              input logic [1:0] srv_en, input logic [1:0] cli_en,
                              input logic [15:0] tmo0, input logic [15:0] tmo1);
        write_reg(REG_SERVER_ID_0, CFG_DATA_W'(id0));
        write_reg(REG_SERVER_ID_1, CFG_DATA_W'(id1));
        write_reg(REG_SERVER_ENABLE, CFG_DATA_W'(srv_en));
        write_reg(REG_CLIENT_ENABLE, CFG_DATA_W'(cli_en));
        write_reg(REG_CLIENT_TIMEOUT_0, CFG_DATA_W'(tmo0));
        write_reg(REG_CLIENT_TIMEOUT_1, CFG_DATA_W'(tmo1));
    endtask

    // wait until everything sent has been answered, then let a request
    // that gives no result settle inside the block
    task automatic wait_drained();
        do
            @(negedge clk);
        while (event_queue.size() != 0 || ev_if.valid || expected_results.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    function automatic event_t make_event(logic [1:0] cmd, logic port,
                                          logic [7:0] id, logic [8:0] size);
        event_t e;
        e.command  = cmd;
        e.port     = port;
        e.msg_id   = id;
        e.msg_size = size;
        return e;
    endfunction

    // mostly well-formed traffic: request ids aimed at the configured servers,
    // lengths mostly valid, with short ones and long ones above 256 mixed in
    function automatic event_t random_event();
        event_t e;
        int roll;
        roll       = $urandom_range(99);
        e.port     = 1'($urandom_range(1));
        e.msg_id   = 8'($urandom_range(255));
        case ($urandom_range(9))
            0:       e.msg_size = 9'($urandom_range(4));
            1:       e.msg_size = 9'($urandom_range(511, 257));
            default: e.msg_size = 9'($urandom_range(256, 5));
        endcase
        if (roll < 35)
        begin
            e.command = CMD_REQUEST;
            case ($urandom_range(3))
                0: e.msg_id = cfg_server_id[0];
                1: e.msg_id = cfg_server_id[1];
                2: e.msg_id = '0;
                default: ;
            endcase
        end
        else if (roll < 65)
            e.command = CMD_RESPONSE;
        else if (roll < 95)
            e.command = CMD_TICK;
        else
            e.command = CMD_UNUSED;
        return e;
    endfunction

    function automatic logic [7:0] pick_server_id();
        case ($urandom_range(4))
            0:       return 8'h00;
            1:       return 8'hff;
            2:       return 8'h5a;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [15:0] pick_timeout();
        if ($urandom_range(7) == 0)
            return 16'hffff;
        return 16'($urandom_range(4));
    endfunction

    function automatic logic [1:0] pick_enable();
        if ($urandom_range(3) == 0)
            return 2'($urandom_range(3));
        return 2'b11;
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        logic [1:0] srv_en;
        logic [1:0] cli_en;
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        error_count    = 0;
        cycle_count    = 0;
        cfg_server_en  = '0;
        cfg_client_en  = '0;
        for (int i = 0; i < NUM_SERVERS; i++)
        begin
            cfg_server_id[i] = '0;
            srv_busy[i]      = 1'b0;
        end
        for (int i = 0; i < NUM_CLIENTS; i++)
        begin
            cfg_timeout[i] = '0;
            cl_phase[i]    = PH_IDLE;
            cl_target[i]   = 1'b0;
            cl_timer[i]    = '0;
            cl_req_id[i]   = '0;
            cl_req_size[i] = '0;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: server 0 on id 0x11, server 1 catch-all, client 0 with
        // no timeout slack, client 1 with two ticks
        set_config(8'h11, 8'h00, 2'b11, 2'b11, 16'd0, 16'd2);
        event_queue.push_back(make_event(CMD_UNUSED, 1'b1, 8'hff, 9'd511));   // unknown command
        event_queue.push_back(make_event(CMD_REQUEST, 1'b0, 8'h11, 9'd4));    // too short
        event_queue.push_back(make_event(CMD_REQUEST, 1'b0, 8'h11, 9'd5));    // exact match
        event_queue.push_back(make_event(CMD_REQUEST, 1'b0, 8'h11, 9'd5));    // client not idle
        event_queue.push_back(make_event(CMD_REQUEST, 1'b1, 8'h11, 9'd256));  // server busy
        event_queue.push_back(make_event(CMD_RESPONSE, 1'b1, 8'h01, 9'd9));   // nobody waiting
        event_queue.push_back(make_event(CMD_RESPONSE, 1'b0, 8'h01, 9'd4));   // short response
        event_queue.push_back(make_event(CMD_TICK, 1'b0, 8'h00, 9'd0));       // timeout + send
        event_queue.push_back(make_event(CMD_RESPONSE, 1'b0, 8'hab, 9'd256)); // to client 1
        event_queue.push_back(make_event(CMD_REQUEST, 1'b1, 8'h55, 9'd511));  // catch-all
        event_queue.push_back(make_event(CMD_TICK, 1'b1, 8'hff, 9'd511));
        event_queue.push_back(make_event(CMD_TICK, 1'b0, 8'h00, 9'd0));
        event_queue.push_back(make_event(CMD_TICK, 1'b0, 8'h00, 9'd0));       // client 1 times out
        event_queue.push_back(make_event(CMD_REQUEST, 1'b0, 8'h00, 9'd300));
        event_queue.push_back(make_event(CMD_RESPONSE, 1'b1, 8'hff, 9'd5));
        wait_drained();

        // directed: ids at the extremes, one server, one client, longest timeouts
        set_config(8'hff, 8'h7f, 2'b01, 2'b01, 16'hffff, 16'hffff);
        event_queue.push_back(make_event(CMD_REQUEST, 1'b1, 8'hff, 9'd6));    // disabled client
        event_queue.push_back(make_event(CMD_REQUEST, 1'b0, 8'h22, 9'd7));    // no route
        event_queue.push_back(make_event(CMD_REQUEST, 1'b0, 8'hff, 9'd6));
        event_queue.push_back(make_event(CMD_TICK, 1'b0, 8'h00, 9'd0));       // countdown only
        event_queue.push_back(make_event(CMD_RESPONSE, 1'b0, 8'h33, 9'd300));
        wait_drained();

        // directed: everything disabled
        set_config(8'hff, 8'h7f, 2'b00, 2'b00, 16'hffff, 16'hffff);
        event_queue.push_back(make_event(CMD_REQUEST, 1'b0, 8'h00, 9'd100));
        event_queue.push_back(make_event(CMD_TICK, 1'b1, 8'h00, 9'd0));
        event_queue.push_back(make_event(CMD_RESPONSE, 1'b1, 8'h10, 9'd100));
        wait_drained();

        // random phases, each under its own settings and idle pattern
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            srv_en = (p == 5) ? 2'b00 : pick_enable();
            cli_en = (p == 6) ? 2'b10 : pick_enable();
            if (p == 0)
            begin
                srv_en = 2'b11;
                cli_en = 2'b11;
            end
            set_config(pick_server_id(), pick_server_id(), srv_en, cli_en,
                       pick_timeout(), pick_timeout());
            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 88;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 88;
                end
                default:
                begin
                    send_idle_pct  = 36;
                    recv_stall_pct = 36;
                end
            endcase
            // the sender stops halfway until every pending result is back
            for (int half = 0; half < 2; half++)
            begin
                for (int n = 0; n < ITEMS_PER_PHASE / 2; n++)
                    event_queue.push_back(random_event());
                wait_drained();
            end
        end

        if (expected_results.size() != 0)
            report_mismatch("results never delivered", expected_results.size(), 0);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
